[rtl/core/fbpa_pkg.sv]
// Shared types and constants of the fixed block pool allocator.
package fbpa_pkg;

  // Pool geometry, fixed by the request and result field widths.
  localparam int unsigned MaxBlocks = 1024;
  localparam int unsigned IdxW      = $clog2(MaxBlocks);
  localparam int unsigned CntW      = $clog2(MaxBlocks + 1);

  localparam logic [CntW-1:0] BlockCountReset = CntW'(MaxBlocks);

  // Operation codes of the func field.
  localparam logic FuncRequest = 1'b0;
  localparam logic FuncRelease = 1'b1;

  typedef enum logic [1:0] {
    StOk      = 2'd0,
    StEmpty   = 2'd1,
    StInvalid = 2'd2
  } status_e;

  typedef enum logic {
    StateIdle = 1'b0,
    StateExec = 1'b1
  } state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic rd_en;   // capture request, launch memory reads
    logic commit;  // apply the update, load the result register
  } ctrl_cmd_t;

endpackage

[rtl/core/fbpa_ctrl.sv]
// Controller of the fixed block pool allocator: state machine and result valid.
module fbpa_ctrl import fbpa_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   slot_free;

  assign slot_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d      = state_q;
    in_ready_o   = 1'b0;
    cmd_o.rd_en  = 1'b0;
    cmd_o.commit = 1'b0;
    unique case (state_q)
      StateIdle: begin
        in_ready_o  = 1'b1;
        cmd_o.rd_en = in_valid_i;
        if (in_valid_i) begin
          state_d = StateExec;
        end
      end
      StateExec: begin
        // hold here while the previous result is still unclaimed
        cmd_o.commit = slot_free;
        if (slot_free) begin
          state_d = StateIdle;
        end
      end
      default: state_d = StateIdle;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.commit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StateIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

[rtl/core/fbpa_datapath.sv]
// Datapath of the fixed block pool allocator: pool state, memories and result register.
module fbpa_datapath import fbpa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  ctrl_cmd_t       cmd_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            func_i,
  input  logic [IdxW-1:0] release_index_i,
  output logic [1:0]      status_o,
  output logic [IdxW-1:0] granted_index_o,
  output logic [CntW-1:0] blocks_in_use_o
);

  // Memories: in-use bitmap and free-list links.
  logic            inuse_mem [MaxBlocks];
  logic [IdxW-1:0] link_mem  [MaxBlocks];

  logic            inuse_rd_q;
  logic [IdxW-1:0] link_rd_q;

  // Captured request.
  logic            func_q;
  logic [IdxW-1:0] rel_q;

  // Pool state.
  logic [CntW-1:0] block_count_q;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic            nonempty_q, nonempty_d;
  logic [CntW-1:0] fill_q, fill_d;
  logic            from_list_q, from_list_d;
  logic [CntW-1:0] used_q, used_d;

  // Result register.
  status_e         status_q, status_d;
  logic [IdxW-1:0] granted_q, granted_d;
  logic [CntW-1:0] out_used_q;

  logic            inuse_we;
  logic [IdxW-1:0] inuse_waddr;
  logic            inuse_wdata;
  logic            link_we;

  logic [CntW-1:0] count;
  logic [CntW-1:0] fill_inc;
  logic [CntW-1:0] used_inc;
  logic            in_use_hit;
  logic            have;
  logic [IdxW-1:0] idx;

  assign count    = (block_count_q > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : block_count_q;
  assign fill_inc = fill_q + CntW'(1);
  assign used_inc = used_q + CntW'(1);

  // Only blocks below the fill counter were ever handed out; the rest read as free.
  assign in_use_hit = inuse_rd_q && ({1'b0, rel_q} < fill_q);

  always_comb begin
    head_d      = head_q;
    tail_d      = tail_q;
    nonempty_d  = nonempty_q;
    fill_d      = fill_q;
    from_list_d = from_list_q;
    used_d      = used_q;
    status_d    = StOk;
    granted_d   = '0;
    inuse_we    = 1'b0;
    inuse_waddr = rel_q;
    inuse_wdata = 1'b0;
    link_we     = 1'b0;
    have        = 1'b0;
    idx         = '0;
    if (func_q == FuncRequest) begin
      if (used_q < count) begin
        if (!from_list_q) begin
          idx    = fill_q[IdxW-1:0];
          have   = 1'b1;
          fill_d = fill_inc;
          if (count <= fill_inc) begin
            from_list_d = 1'b1;
          end
        end else if (nonempty_q) begin
          idx  = head_q;
          have = 1'b1;
          if (head_q == tail_q) begin
            nonempty_d = 1'b0;
          end else begin
            head_d = link_rd_q;
          end
        end
      end
      if (have) begin
        inuse_we    = 1'b1;
        inuse_waddr = idx;
        inuse_wdata = 1'b1;
        used_d      = used_inc;
        granted_d   = idx;
        // pool full: drop the free list
        if (count <= used_inc) begin
          nonempty_d = 1'b0;
          head_d     = '0;
          tail_d     = '0;
        end
      end else begin
        status_d = StEmpty;
      end
    end else begin
      if (({1'b0, rel_q} >= count) || !in_use_hit) begin
        status_d = StInvalid;
      end else begin
        inuse_we = 1'b1;
        if (used_q != '0) begin
          used_d = used_q - CntW'(1);
        end
        if (!nonempty_q) begin
          head_d     = rel_q;
          tail_d     = rel_q;
          nonempty_d = 1'b1;
        end else begin
          link_we = 1'b1;
          tail_d  = rel_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      block_count_q <= BlockCountReset;
      head_q        <= '0;
      tail_q        <= '0;
      nonempty_q    <= 1'b0;
      fill_q        <= '0;
      from_list_q   <= 1'b0;
      used_q        <= '0;
    end else begin
      if (cfg_we_i) begin
        block_count_q <= cfg_wdata_i;
      end
      if (cmd_i.commit) begin
        head_q      <= head_d;
        tail_q      <= tail_d;
        nonempty_q  <= nonempty_d;
        fill_q      <= fill_d;
        from_list_q <= from_list_d;
        used_q      <= used_d;
      end
    end
  end

  // Request capture and registered memory reads.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      func_q     <= func_i;
      rel_q      <= release_index_i;
      inuse_rd_q <= inuse_mem[release_index_i];
      link_rd_q  <= link_mem[head_q];
    end
  end

  // Memory writes.
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && inuse_we) begin
      inuse_mem[inuse_waddr] <= inuse_wdata;
    end
    if (cmd_i.commit && link_we) begin
      link_mem[tail_q] <= rel_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      status_q   <= status_d;
      granted_q  <= granted_d;
      out_used_q <= used_d;
    end
  end

  assign status_o        = status_q;
  assign granted_index_o = granted_q;
  assign blocks_in_use_o = out_used_q;

endmodule

[rtl/core/fixed_block_pool_allocator_unit.sv]
// Top level of the fixed block pool allocator.
//
// Input channel (in_valid_i / in_ready_o): one request per handshake.
// func_i selects a block request or a release of release_index_i.
// Output channel (out_valid_o / out_ready_i): exactly one result per
// request with status_o, granted_index_o and blocks_in_use_o.
// Configuration: cfg_we_i writes cfg_wdata_i into the block count; write
// it only while no request is in flight.
//
// Sequence: when a request is taken, the in-use bitmap and the free-list
// link memory are read at that edge; the commit in the execute state then
// applies the update and loads the result register. No new request is
// taken until the previous one has been committed.
// A result waiting on a stalled receiver does not block the next request
// from being taken; that request then holds in execution until the result
// register frees up.
// Reset: clears the controller, the free list, the fill counter and the
// in-use count, and sets the block count to its maximum; the bitmap needs
// no clearing pass since entries at or above the fill counter read as free.
module fixed_block_pool_allocator_unit import fbpa_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  logic            in_valid_i,
  output logic            in_ready_o,
  input  logic            func_i,
  input  logic [IdxW-1:0] release_index_i,
  output logic            out_valid_o,
  input  logic            out_ready_i,
  output logic [1:0]      status_o,
  output logic [IdxW-1:0] granted_index_o,
  output logic [CntW-1:0] blocks_in_use_o
);

  ctrl_cmd_t cmd;

  // Sequence capture, commit and result handshake.
  fbpa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd)
  );

  // Hold pool state and compute each grant or release.
  fbpa_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .func_i          (func_i),
    .release_index_i (release_index_i),
    .status_o        (status_o),
    .granted_index_o (granted_index_o),
    .blocks_in_use_o (blocks_in_use_o)
  );

endmodule

[rtl/core/fbpa_checker.sv]
// Port-level assertions of the fixed block pool allocator and their binding.
module fbpa_checker import fbpa_pkg::*; (
  input logic            clk_i,
  input logic            rst_ni,
  input logic            in_valid_i,
  input logic            in_ready_o,
  input logic            out_valid_o,
  input logic            out_ready_i,
  input logic [1:0]      status_o,
  input logic [IdxW-1:0] granted_index_o,
  input logic [CntW-1:0] blocks_in_use_o
);

  // A result holds until taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(status_o)
      && $stable(granted_index_o) && $stable(blocks_in_use_o))
    else $error("result changed while stalled");

  // One request at a time: no new request right after one is taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o)
    else $error("request taken back to back");

  // Failed operations never report a granted block.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (status_o != StOk) |-> granted_index_o == '0)
    else $error("granted index nonzero on failure");

  // The in-use count never exceeds the pool size.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> blocks_in_use_o <= CntW'(MaxBlocks))
    else $error("in-use count out of range");

endmodule

bind fixed_block_pool_allocator_unit fbpa_checker u_fbpa_checker (.*);

[tb/sv/tb.sv]
// Self-checking testbench for the fixed block pool allocator unit.
module tb;
  import fbpa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned MaxReports = 10;

  // One request as offered on the input channel.
  typedef struct {
    logic            func;
    logic [IdxW-1:0] index;
  } pool_req_t;

  // One expected answer on the result channel.
  typedef struct {
    status_e         status;
    logic [IdxW-1:0] granted;
    logic [CntW-1:0] in_use;
  } pool_ans_t;

  logic            clk_i   = 1'b0;
  logic            rst_ni  = 1'b0;
  logic            cfg_we  = 1'b0;
  logic [CntW-1:0] cfg_wdata = '0;
  logic            in_valid = 1'b0;
  logic            in_ready;
  logic            func    = FuncRequest;
  logic [IdxW-1:0] release_idx = '0;
  logic            out_valid;
  logic            out_ready = 1'b0;
  logic [1:0]      status;
  logic [IdxW-1:0] granted_index;
  logic [CntW-1:0] blocks_in_use;

  fixed_block_pool_allocator_unit DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata),
    .in_valid_i      (in_valid),
    .in_ready_o      (in_ready),
    .func_i          (func),
    .release_index_i (release_idx),
    .out_valid_o     (out_valid),
    .out_ready_i     (out_ready),
    .status_o        (status),
    .granted_index_o (granted_index),
    .blocks_in_use_o (blocks_in_use)
  );

  // 4 ns period.
  always begin
    clk_i = 1'b1;
    #2;
    clk_i = 1'b0;
    #2;
  end

  // ---------------------------------------------------------------------------
  // Shadow pool: mirrors the allocator state, advanced once per accepted
  // request in acceptance order.
  // ---------------------------------------------------------------------------
  logic [CntW-1:0] pool_count;        // block count register as written
  logic            busy_map [MaxBlocks];
  logic [IdxW-1:0] link_tbl [MaxBlocks];
  logic [IdxW-1:0] list_first;
  logic [IdxW-1:0] list_last;
  logic            list_live;
  logic [CntW-1:0] fill_next;
  logic            recycle_mode;      // fill counter exhausted, serve from list
  logic [CntW-1:0] blocks_taken;

  function automatic logic [CntW-1:0] usable_blocks();
    return (pool_count > CntW'(MaxBlocks)) ? CntW'(MaxBlocks) : pool_count;
  endfunction

  task automatic pool_clear();
    pool_count   = BlockCountReset;
    for (int i = 0; i < MaxBlocks; i++) begin
      busy_map[i] = 1'b0;
      link_tbl[i] = '0;
    end
    list_first   = '0;
    list_last    = '0;
    list_live    = 1'b0;
    fill_next    = '0;
    recycle_mode = 1'b0;
    blocks_taken = '0;
  endtask

  // Apply one request to the shadow pool and return the answer it must give.
  task automatic pool_apply(input pool_req_t rq, output pool_ans_t ans);
    logic [CntW-1:0] limit;
    logic            got;
    logic [CntW-1:0] pick;
    limit       = usable_blocks();
    got         = 1'b0;
    pick        = '0;
    ans.status  = StOk;
    ans.granted = '0;
    if (rq.func == FuncRequest) begin
      if (blocks_taken < limit) begin
        if (!recycle_mode) begin
          // Still handing out fresh blocks in order.
          pick      = fill_next;
          got       = 1'b1;
          fill_next = fill_next + 1'b1;
          if (limit <= fill_next) recycle_mode = 1'b1;
        end else if (list_live) begin
          // Pop the free-list head; a single entry empties the list.
          pick = CntW'(list_first);
          got  = 1'b1;
          if (list_first == list_last) list_live = 1'b0;
          else list_first = link_tbl[list_first];
        end
      end
      if (got && pick < CntW'(MaxBlocks)) begin
        busy_map[pick[IdxW-1:0]] = 1'b1;
        blocks_taken = blocks_taken + 1'b1;
        ans.granted  = pick[IdxW-1:0];
        // A full pool drops whatever was left on the free list.
        if (limit <= blocks_taken) begin
          list_live  = 1'b0;
          list_first = '0;
          list_last  = '0;
        end
      end else begin
        ans.status = StEmpty;
      end
    end else begin
      if (CntW'(rq.index) >= limit || !busy_map[rq.index]) begin
        ans.status = StInvalid;
      end else begin
        busy_map[rq.index] = 1'b0;
        if (blocks_taken > 0) blocks_taken = blocks_taken - 1'b1;
        if (!list_live) begin
          list_first = rq.index;
          list_last  = rq.index;
          list_live  = 1'b1;
        end else begin
          link_tbl[list_last] = rq.index;
          list_last = rq.index;
        end
      end
    end
    ans.in_use = blocks_taken;
  endtask

  // ---------------------------------------------------------------------------
  // Shared run state.
  // ---------------------------------------------------------------------------
  pool_req_t pending_reqs [$];
  pool_ans_t due_answers  [$];
  pool_req_t on_wire;
  int        idle_pct  = 0;     // chance per cycle of starting an idle burst
  bit        calm      = 1'b0;  // last stretch: no idling on either side
  bit        hold_rx   = 1'b0;  // long receiver hold-off
  int        n_taken   = 0;
  int        n_errors  = 0;
  int        cycles    = 0;

  task automatic flag_error(input string msg);
    n_errors++;
    if (n_errors <= MaxReports) $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: present queued requests, hold them until taken, and idle in
  // random bursts. Prediction happens at the accepting edge.
  // ---------------------------------------------------------------------------
  int        tx_gap = 0;
  pool_ans_t tx_ans;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        pool_apply(on_wire, tx_ans);
        due_answers.push_back(tx_ans);
        n_taken++;
      end
      // Advance only when nothing is on the wire or it was just taken.
      if (!in_valid || in_ready) begin
        if (tx_gap == 0 && !calm && $urandom_range(0, 99) < idle_pct)
          tx_gap = $urandom_range(1, 12);
        if (tx_gap > 0) begin
          tx_gap--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() > 0) begin
          on_wire = pending_reqs.pop_front();
          in_valid    <= 1'b1;
          func        <= on_wire.func;
          release_idx <= on_wire.index;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each accepted result against the oldest expectation and
  // stall the result channel in random bursts.
  // ---------------------------------------------------------------------------
  int        rx_gap = 0;
  pool_ans_t rx_want;

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_gap = 0;
    end else begin
      if (out_valid && out_ready) begin
        if (due_answers.size() == 0) begin
          flag_error($sformatf("unexpected result status=%0d granted=%0d in_use=%0d",
                               status, granted_index, blocks_in_use));
        end else begin
          rx_want = due_answers.pop_front();
          if (status !== rx_want.status)
            flag_error($sformatf("status: expected %0d, got %0d", rx_want.status, status));
          if (granted_index !== rx_want.granted)
            flag_error($sformatf("granted_index: expected %0d, got %0d",
                                 rx_want.granted, granted_index));
          if (blocks_in_use !== rx_want.in_use)
            flag_error($sformatf("blocks_in_use: expected %0d, got %0d",
                                 rx_want.in_use, blocks_in_use));
        end
      end
      if (rx_gap == 0 && !calm && $urandom_range(0, 99) < idle_pct)
        rx_gap = $urandom_range(1, 12);
      if (rx_gap > 0) begin
        rx_gap--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= !hold_rx;
      end
    end
  end

  // Long receiver hold-off while the sender keeps going, so the result
  // register and the execute stage both fill and the input backs up.
  initial begin
    wait (n_taken >= 300);
    @(posedge clk_i);
    hold_rx <= 1'b1;
    repeat (300) @(posedge clk_i);
    hold_rx <= 1'b0;
  end

  // Watchdog.
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CycleLimit) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers.
  // ---------------------------------------------------------------------------

  // Keep the pending queue shallow so release picks track the shadow pool.
  task automatic offer(input logic fn, input logic [IdxW-1:0] idx);
    pool_req_t rq;
    rq.func  = fn;
    rq.index = idx;
    while (pending_reqs.size() >= 2) @(negedge clk_i);
    pending_reqs.push_back(rq);
  endtask

  // Wait until nothing is queued, on the wire or outstanding, then let the
  // pipeline settle.
  task automatic wait_drain();
    do @(negedge clk_i);
    while (pending_reqs.size() != 0 || in_valid || due_answers.size() != 0);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_count(input logic [CntW-1:0] value);
    wait_drain();
    @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    pool_count = value;
    cfg_we    <= 1'b0;
  endtask

  // Pick a block the shadow pool holds as allocated, preferring ones below
  // the count; fall back to any index when no held block is picked.
  function automatic logic [IdxW-1:0] pick_busy();
    int          start;
    int          slot;
    logic [CntW-1:0] limit;
    start = $urandom_range(0, MaxBlocks - 1);
    limit = usable_blocks();
    for (int k = 0; k < MaxBlocks; k++) begin
      slot = (start + k) % MaxBlocks;
      if (busy_map[slot] && (slot < limit || $urandom_range(0, 9) == 0))
        return IdxW'(slot);
    end
    return IdxW'($urandom_range(0, MaxBlocks - 1));
  endfunction

  // Random traffic: requests at req_pct percent, otherwise releases, mostly of held blocks, some noise.
  task automatic random_traffic(input int n, input int req_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < req_pct)
        offer(FuncRequest, IdxW'($urandom));
      else if ($urandom_range(0, 99) < 80)
        offer(FuncRelease, pick_busy());
      else
        offer(FuncRelease, IdxW'($urandom_range(0, MaxBlocks - 1)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Test sequence.
  // ---------------------------------------------------------------------------
  int phase_count [9] = '{600, 16, 2047, 3, 0, 1, 64, 1024, 0};
  int phase_req   [9] = '{30, 60, 55, 50, 50, 50, 60, 45, 55};

  initial begin
    pool_clear();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    idle_pct = 15;

    // Directed: reset count, fill counter kept below the count throughout.
    offer(FuncRelease, IdxW'(0));             // nothing held yet
    offer(FuncRelease, IdxW'(MaxBlocks - 1)); // top index, not held
    offer(FuncRequest, '0);
    offer(FuncRequest, '1);
    offer(FuncRelease, IdxW'(1));
    offer(FuncRelease, IdxW'(1));             // double release
    offer(FuncRelease, IdxW'(0));
    offer(FuncRequest, '0);

    // Count zero: every request empty, every release invalid.
    write_count('0);
    offer(FuncRequest, '0);
    offer(FuncRelease, IdxW'(2));

    // Count above the pool size saturates.
    write_count('1);
    offer(FuncRequest, '1);
    offer(FuncRelease, IdxW'(3));

    // Count lowered to the number of blocks in use: full, and held block now out of range.
    write_count(CntW'(1));
    offer(FuncRequest, '0);
    offer(FuncRelease, IdxW'(2));
    offer(FuncRelease, IdxW'(0));

    write_count(BlockCountReset);
    offer(FuncRelease, IdxW'(2));

    // Fill the whole pool from the fill counter, spill over into the free
    // list, and hit the full condition.
    idle_pct = 10;
    random_traffic(1150, 95);

    // Shrink, saturate, zero and regrow the count across phases; the run
    // alternates between heavy idling, light idling and none.
    for (int p = 0; p < 9; p++) begin
      if (p == 8) write_count(CntW'($urandom_range(2, 40)));
      else write_count(CntW'(phase_count[p]));
      case (p % 3)
        0:       idle_pct = 0;
        1:       idle_pct = 8;
        default: idle_pct = 25;
      endcase
      if (p == 8) calm = 1'b1;
      random_traffic(95, phase_req[p]);
    end

    wait_drain();
    repeat (10) @(posedge clk_i);
    if (n_errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[fixed_block_pool_allocator_unit.f]
rtl/core/fbpa_pkg.sv
rtl/core/fbpa_ctrl.sv
rtl/core/fbpa_datapath.sv
rtl/core/fixed_block_pool_allocator_unit.sv
rtl/core/fbpa_checker.sv
tb/sv/tb.sv
